// ===== design/rbnh_pkg.sv =====
package rbnh_pkg;

    localparam int MAX_BOXES = 4096;
    localparam int CNT_W     = $clog2(MAX_BOXES);
    localparam int IDX_W     = 12;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 18;
    localparam int DIST_W  = 32;

    // numerator magnitude: |bound - origin| (33 bits) shifted left by 16
    localparam int NUM_W = 49;
    // quotient register, padded to an even width for two bits per cycle
    localparam int QUO_W = 50;
    localparam int REM_W = DIR_W + 1;
    localparam int DIV_ITER = QUO_W / 2;
    localparam int ITER_W = $clog2(DIV_ITER + 1);
    // signed distance along the ray
    localparam int T_W = QUO_W + 1;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DIR_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== design/rbnh_div.sv =====
module rbnh_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rbnh_pkg::div_req_t req,
    output rbnh_pkg::div_rsp_t rsp
);
    import rbnh_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DIR_W-1:0]  den_reg;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] r1, r1s, r2, r2s;
    logic [QUO_W-1:0] q1;
    logic             ge1, ge2;

    // two restoring steps per cycle
    always_comb
    begin
        den_ext = {1'b0, den_reg};
        r1  = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
        ge1 = (r1 >= den_ext);
        r1s = ge1 ? (r1 - den_ext) : r1;
        q1  = {quo_reg[QUO_W-2:0], ge1};
        r2  = {r1s[REM_W-2:0], q1[QUO_W-1]};
        ge2 = (r2 >= den_ext);
        r2s = ge2 ? (r2 - den_ext) : r2;
    end

    // advance the iteration
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = {{(QUO_W-NUM_W){1'b0}}, req.num};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = r2s;
            quo_next = {q1[QUO_W-2:0], ge2};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(DIV_ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== design/ray_box_nearest_hit_top.sv =====
// Sequence: each slab distance takes a setup state (S_SETUP), the divider at two
// quotient bits per cycle and its done flag (S_DIV); each dividing axis adds a compare
// state (S_AXIS), then S_FINAL and S_OUT end the box. An axis that is parallel or an
// axis that already shows a miss shortens the run.
// Boxes: one at a time; input is ready again once the result is loaded.
// Reset: origin 0, direction (0,0,1.0), set state cleared (no hit, distance all ones).
module ray_box_nearest_hit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] min_x,
    input  logic signed [31:0] min_y,
    input  logic signed [31:0] min_z,
    input  logic signed [31:0] max_x,
    input  logic signed [31:0] max_y,
    input  logic signed [31:0] max_z,
    input  logic        last_box,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] hit_distance,
    output logic [11:0] best_index,
    output logic [31:0] best_distance,
    output logic        any_hit,
    output logic        set_done
);
    import rbnh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_AXIS  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic signed [T_W-1:0] T_LOW  = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_HIGH = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_SAT  = T_W'(64'hFFFF_FFFF);

    // configuration
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [DIR_W-1:0]   dir_reg [3];

    // box beat
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];
    logic                      last_reg;

    // sequencer
    logic [2:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       side_reg, side_next;
    logic       neg_reg;
    logic       miss_reg, miss_next;
    logic signed [T_W-1:0] t1_reg, tmin_reg, tmin_next, tmax_reg, tmax_next;
    logic       hit_reg;
    logic [DIST_W-1:0] dist_reg;

    // set state
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIST_W-1:0] near_dist_reg;
    logic [CNT_W-1:0]  near_idx_reg;
    logic              found_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic signed [COORD_W-1:0] cur_org, cur_bound;
    logic signed [DIR_W-1:0]   cur_dir;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W:0]          diff_mag;
    logic                      cur_neg;
    logic signed [T_W-1:0]     t_cur, t_lo, t_hi, tsel;
    logic                      par_miss, take_best, out_free;

    rbnh_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    // pick the operands of the current axis and bound
    always_comb
    begin
        cur_org   = org_reg[axis_reg];
        cur_dir   = dir_reg[axis_reg];
        cur_bound = side_reg ? hi_reg[axis_reg] : lo_reg[axis_reg];
        diff      = {cur_bound[COORD_W-1], cur_bound} - {cur_org[COORD_W-1], cur_org};
        diff_mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
        cur_neg   = diff[COORD_W] ^ cur_dir[DIR_W-1];
        par_miss  = (cur_org < lo_reg[axis_reg]) || (cur_org > hi_reg[axis_reg]);
        dreq.num  = {diff_mag, 16'b0};
        dreq.den  = cur_dir[DIR_W-1] ? DIR_W'(-cur_dir) : cur_dir;
        dreq.start = (state_reg == S_SETUP) && (cur_dir != '0);
        t_cur = neg_reg ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
        t_lo  = (t1_reg > t_cur) ? t_cur : t1_reg;
        t_hi  = (t1_reg > t_cur) ? t1_reg : t_cur;
        tsel  = (tmin_reg >= 0) ? tmin_reg : tmax_reg;
    end

    assign out_free  = !out_valid || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign take_best = hit_reg && (!found_reg || (dist_reg < near_dist_reg));

    // sequence the axes, bounds and divisions
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        side_next  = side_reg;
        miss_next  = miss_reg;
        tmin_next  = tmin_reg;
        tmax_next  = tmax_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SETUP;
                    axis_next  = 2'd0;
                    side_next  = 1'b0;
                    miss_next  = 1'b0;
                    tmin_next  = T_LOW;
                    tmax_next  = T_HIGH;
                end
            end
            S_SETUP:
            begin
                if (cur_dir != '0)
                begin
                    state_next = S_DIV;
                end
                else if (par_miss)
                begin
                    miss_next  = 1'b1;
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = (axis_reg == 2'd2) ? S_FINAL : S_SETUP;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        state_next = S_AXIS;
                        if (t_lo > tmin_reg)
                        begin
                            tmin_next = t_lo;
                        end
                        if (t_hi < tmax_reg)
                        begin
                            tmax_next = t_hi;
                        end
                    end
                end
            end
            S_AXIS:
            begin
                side_next = 1'b0;
                if (tmin_reg > tmax_reg)
                begin
                    miss_next  = 1'b1;
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = (axis_reg == 2'd2) ? S_FINAL : S_SETUP;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_FINAL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            side_reg      <= 1'b0;
            miss_reg      <= 1'b0;
            out_valid     <= 1'b0;
            cnt_reg       <= '0;
            near_dist_reg <= '1;
            near_idx_reg  <= '0;
            found_reg     <= 1'b0;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= DIR_Z_RESET;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            side_reg  <= side_next;
            miss_reg  <= miss_next;

            // take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ORIGIN_X: org_reg[0] <= cfg_data;
                    REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                    REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                    REG_DIR_X:    dir_reg[0] <= cfg_data[DIR_W-1:0];
                    REG_DIR_Y:    dir_reg[1] <= cfg_data[DIR_W-1:0];
                    REG_DIR_Z:    dir_reg[2] <= cfg_data[DIR_W-1:0];
                    default:      ;
                endcase
            end

            // load the result and update the set state
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid <= 1'b1;
                if (last_reg)
                begin
                    cnt_reg       <= '0;
                    near_dist_reg <= '1;
                    near_idx_reg  <= '0;
                    found_reg     <= 1'b0;
                end
                else
                begin
                    if (cnt_reg != CNT_W'(MAX_BOXES - 1))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (take_best)
                    begin
                        near_dist_reg <= dist_reg;
                        near_idx_reg  <= cnt_reg;
                    end
                    if (hit_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
            // drop the result beat once taken
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lo_reg[0] <= min_x;
            lo_reg[1] <= min_y;
            lo_reg[2] <= min_z;
            hi_reg[0] <= max_x;
            hi_reg[1] <= max_y;
            hi_reg[2] <= max_z;
            last_reg  <= last_box;
        end
        tmin_reg <= tmin_next;
        tmax_reg <= tmax_next;
        if (state_reg == S_SETUP)
        begin
            neg_reg <= cur_neg;
        end
        if ((state_reg == S_DIV) && drsp.done && !side_reg)
        begin
            t1_reg <= t_cur;
        end
        if (state_reg == S_FINAL)
        begin
            hit_reg  <= !miss_reg && (tsel >= 0);
            dist_reg <= (miss_reg || (tsel < 0)) ? '0 :
                        (tsel > T_SAT) ? '1 : tsel[DIST_W-1:0];
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            hit           <= hit_reg;
            hit_distance  <= dist_reg;
            best_index    <= IDX_W'(take_best ? cnt_reg : near_idx_reg);
            best_distance <= take_best ? dist_reg : near_dist_reg;
            any_hit       <= found_reg || hit_reg;
            set_done      <= last_reg;
        end
    end

endmodule

// ===== design/rbnh_checker.sv =====
module rbnh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [31:0] hit_distance,
    input logic [11:0] best_index,
    input logic [31:0] best_distance,
    input logic        any_hit
);

    // busy after a box is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still ready after accept");

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_distance) && $stable(best_index))
        else $error("stalled result changed");

    // a miss reports zero distance
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == 32'd0)
        else $error("miss with nonzero distance");

    // a hit marks the set as hit, and the best is no farther
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> any_hit && (best_distance <= hit_distance))
        else $error("hit not reflected in best");

    // no hit yet leaves the best at its cleared value
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_hit |-> best_distance == 32'hFFFF_FFFF && best_index == 12'd0)
        else $error("best set without a hit");

endmodule

bind ray_box_nearest_hit_top rbnh_checker u_rbnh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_distance (hit_distance),
    .best_index   (best_index),
    .best_distance(best_distance),
    .any_hit      (any_hit)
);
